// File: sv/dwc_pkg.sv
package dwc_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 7;
    localparam int TDATA_W = 8;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t SEPARATOR = 8'h20;
    localparam char_t NUL_CHAR  = 8'h00;

endpackage

// File: sv/distinct_word_counter.sv
// Channel | Ports                                  | Item
// --------+----------------------------------------+--------------------------------------
// input   | s_tvalid s_tready s_tdata s_tlast      | one character, or a line end (tlast)
// result  | m_tvalid m_tready m_tdata m_tuser      | distinct count and overflow flag
//
// A word end walks the stored words, reading each length and, when the lengths agree,
// reading and comparing its characters; when no word matches, the new word is copied
// in character by character. A line end then loads the result register. Each memory
// has a single read port.
// Reset is synchronous, active low, and clears only control state; memories hold garbage
// until written. A waiting result blocks only the next line end, not characters.
module distinct_word_counter #(
    parameter int MAX_WORDS    = 64,
    parameter int MAX_WORD_LEN = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dwc_pkg::TDATA_W-1:0]   s_tdata,  // [7:0] character
    input  logic                          s_tlast,  // line_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dwc_pkg::TDATA_W-1:0]   m_tdata,  // [6:0] distinct_count, [7] zero
    output logic [0:0]                    m_tuser   // [0] overflow
);

    import dwc_pkg::*;

    // Widths of lengths, counts and memory addresses
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int PA_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int SC_W  = $clog2(MAX_WORDS + 1);
    localparam int WA_W  = $clog2(MAX_WORDS);
    localparam int CDEP  = MAX_WORDS * MAX_WORD_LEN;
    localparam int CA_W  = $clog2(CDEP);
    localparam int CB_W  = $clog2(CDEP + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FIND    = 3'd1;
    localparam logic [2:0] S_LEN     = 3'd2;
    localparam logic [2:0] S_CHR_RD  = 3'd3;
    localparam logic [2:0] S_CHR_CMP = 3'd4;
    localparam logic [2:0] S_CP_RD   = 3'd5;
    localparam logic [2:0] S_CP_WR   = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0]      state_reg,    state_next;
    logic [LEN_W-1:0] pend_len_reg, pend_len_next;
    logic [SC_W-1:0]  stored_reg,   stored_next;
    logic             ovf_reg,      ovf_next;
    logic             emit_reg,     emit_next;
    logic [SC_W-1:0]  idx_reg,      idx_next;
    logic [CB_W-1:0]  base_reg,     base_next;
    logic [LEN_W-1:0] k_reg,        k_next;
    logic             m_valid_reg,  m_valid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic             m_ovf_reg,    m_ovf_next;

    logic             s_fire;
    char_t            in_char;
    logic             is_sep;
    logic [LEN_W-1:0] k_inc;
    logic             k_last;
    logic [CB_W-1:0]  wc_addr_full;
    logic [SC_W+COUNT_W-1:0] count_ext;

    logic             pw_we;
    char_t            pw_rdata;
    logic             wc_we;
    char_t            wc_rdata;
    logic             wl_we;
    logic [LEN_W-1:0] wl_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_char  = s_tdata[CHAR_W-1:0];
    assign is_sep   = (in_char == SEPARATOR) || (in_char == NUL_CHAR);

    assign k_inc        = k_reg + LEN_W'(1);
    assign k_last       = (k_inc == pend_len_reg);
    assign wc_addr_full = base_reg + CB_W'(k_reg);
    assign count_ext    = {{COUNT_W{1'b0}}, stored_reg};

    // Pending word: written as characters arrive, read during compare and copy
    assign pw_we = s_fire && !s_tlast && !is_sep && (pend_len_reg < LEN_W'(MAX_WORD_LEN));

    dwc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WORD_LEN)
    ) u_pend_ram (
        .aclk  (aclk),
        .we    (pw_we),
        .waddr (pend_len_reg[PA_W-1:0]),
        .wdata (in_char),
        .raddr (k_reg[PA_W-1:0]),
        .rdata (pw_rdata)
    );

    // Stored word characters, one row of MAX_WORD_LEN per word
    assign wc_we = (state_reg == S_CP_WR);

    dwc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CDEP)
    ) u_char_ram (
        .aclk  (aclk),
        .we    (wc_we),
        .waddr (wc_addr_full[CA_W-1:0]),
        .wdata (pw_rdata),
        .raddr (wc_addr_full[CA_W-1:0]),
        .rdata (wc_rdata)
    );

    // Stored word lengths; written with the last character of a new word
    assign wl_we = (state_reg == S_CP_WR) && k_last;

    dwc_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_WORDS)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (wl_we),
        .waddr (stored_reg[WA_W-1:0]),
        .wdata (pend_len_reg),
        .raddr (idx_reg[WA_W-1:0]),
        .rdata (wl_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        pend_len_next = pend_len_reg;
        stored_next   = stored_reg;
        ovf_next      = ovf_reg;
        emit_next     = emit_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg;
        m_count_next  = m_count_reg;
        m_ovf_next    = m_ovf_reg;

        // Drop the result once the sink takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tlast || is_sep) begin
                        emit_next = s_tlast;
                        idx_next  = '0;
                        base_next = '0;
                        if (pend_len_reg != '0) begin
                            state_next = S_FIND;
                        end else if (s_tlast) begin
                            state_next = S_EMIT;
                        end
                    end else if (pend_len_reg < LEN_W'(MAX_WORD_LEN)) begin
                        pend_len_next = pend_len_reg + LEN_W'(1);
                    end else begin
                        // Truncate the long word and flag it
                        ovf_next = 1'b1;
                    end
                end
            end
            S_FIND: begin
                if (idx_reg == stored_reg) begin
                    // No stored word matched: store it if there is room
                    if (stored_reg < SC_W'(MAX_WORDS)) begin
                        k_next     = '0;
                        state_next = S_CP_RD;
                    end else begin
                        ovf_next      = 1'b1;
                        pend_len_next = '0;
                        state_next    = emit_reg ? S_EMIT : S_IDLE;
                    end
                end else begin
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                if (wl_rdata == pend_len_reg) begin
                    k_next     = '0;
                    state_next = S_CHR_RD;
                end else begin
                    idx_next   = idx_reg + SC_W'(1);
                    base_next  = base_reg + CB_W'(MAX_WORD_LEN);
                    state_next = S_FIND;
                end
            end
            S_CHR_RD: begin
                state_next = S_CHR_CMP;
            end
            S_CHR_CMP: begin
                if (pw_rdata != wc_rdata) begin
                    idx_next   = idx_reg + SC_W'(1);
                    base_next  = base_reg + CB_W'(MAX_WORD_LEN);
                    state_next = S_FIND;
                end else if (k_last) begin
                    // Duplicate word: discard it
                    pend_len_next = '0;
                    state_next    = emit_reg ? S_EMIT : S_IDLE;
                end else begin
                    k_next     = k_inc;
                    state_next = S_CHR_RD;
                end
            end
            S_CP_RD: begin
                state_next = S_CP_WR;
            end
            S_CP_WR: begin
                if (k_last) begin
                    stored_next   = stored_reg + SC_W'(1);
                    pend_len_next = '0;
                    state_next    = emit_reg ? S_EMIT : S_IDLE;
                end else begin
                    k_next     = k_inc;
                    state_next = S_CP_RD;
                end
            end
            S_EMIT: begin
                // Load the result register once it is free, then clear the line
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_ext[COUNT_W-1:0];
                    m_ovf_next   = ovf_reg;
                    stored_next  = '0;
                    ovf_next     = 1'b0;
                    emit_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pend_len_reg <= '0;
            stored_reg   <= '0;
            ovf_reg      <= 1'b0;
            emit_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_len_reg <= pend_len_next;
            stored_reg   <= stored_next;
            ovf_reg      <= ovf_next;
            emit_reg     <= emit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        k_reg       <= k_next;
        m_count_reg <= m_count_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_count_reg);
    assign m_tuser  = m_ovf_reg;

`ifndef SYNTHESIS
    a_pend_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_len_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("pending length beyond word limit");

    a_stored_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_reg <= SC_W'(MAX_WORDS))
        else $error("stored word count beyond table size");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEN || state_reg == S_CHR_RD || state_reg == S_CHR_CMP)
        |-> (idx_reg < stored_reg))
        else $error("walk index past stored words");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && (!m_valid_reg || m_tready)) |=> (m_valid_reg && stored_reg == '0))
        else $error("line end did not load result and clear table");
`endif

endmodule

// File: sv/dwc_ram.sv
module dwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
